// ----- rtl/fys_pkg.sv -----
// Shared types, constants and helpers for the xorshift Fisher-Yates shuffler.
// No dependencies; every RTL file uses this package.
package fys_pkg;

  localparam int MAX_ELEMENTS  = 64;
  localparam int ELEMENT_WIDTH = 16;
  localparam int VALUE_W       = 16;
  localparam int CNT_W         = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W         = $clog2(MAX_ELEMENTS);

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;
  localparam int HASH_SHIFT    = 5;   // hash * 31 = (hash << 5) - hash
  localparam int XS_SHL        = 11;
  localparam int XS_SHR_W3     = 19;
  localparam int XS_SHR_T      = 8;

  typedef enum logic [1:0] {
    CMD_SEED = 2'b01,
    CMD_LOAD = 2'b10
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic                 restart;
    logic                 last;
    logic [VALUE_W-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic       seed;
    logic       restart;
    logic [7:0] seed_byte;
    logic       step;
  } rng_ctl_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] word;
  } rng_sts_t;

  // All ones up to and including the highest set bit of limit.
  function automatic logic [CNT_W-1:0] bit_length_mask(input logic [CNT_W-1:0] limit);
    logic [CNT_W-1:0] m;
    m = limit;
    for (int k = 0; k < CNT_W; k++) begin
      m = m | (m >> 1);
    end
    return m;
  endfunction

endpackage

// ----- rtl/fys_in_if.sv -----
// Input channel of the shuffler: valid/ready handshake plus one input item.
// Depends on fys_pkg for the payload width.
interface fys_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [fys_pkg::VALUE_W-1:0] item_value;
  logic                        seed_start;
  logic                        set_last;

  modport source (output valid, mode, item_value, seed_start, set_last, input ready);
  modport sink   (input valid, mode, item_value, seed_start, set_last, output ready);
endinterface

// ----- rtl/fys_out_if.sv -----
// Result channel of the shuffler: valid/ready handshake plus one result item.
// Depends on fys_pkg for the payload width.
interface fys_out_if;
  logic                        valid;
  logic                        ready;
  logic [fys_pkg::VALUE_W-1:0] out_value;
  logic                        out_last;
  logic                        out_overflow;

  modport source (output valid, out_value, out_last, out_overflow, input ready);
  modport sink   (input valid, out_value, out_last, out_overflow, output ready);
endinterface

// ----- rtl/fys_front.sv -----
// Front end: accepts input transactions, classifies them into commands and
// queues them for the back end. Depends on fys_pkg and fys_in_if.
module fys_front (
  input  logic          clk,
  input  logic          rst,
  fys_in_if.sink        items,
  input  logic          pop,
  output fys_pkg::cmd_t cmd,
  output logic          cmd_valid
);
  import fys_pkg::*;

  cmd_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              take;
  cmd_t              incoming;

  assign items.ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign push        = items.valid && items.ready;
  assign cmd_valid   = (fill != '0);
  assign take        = pop && cmd_valid;
  assign cmd         = q[rd_ptr];

  // Classify: mode selects seed byte or element load.
  always_comb begin
    incoming.kind    = items.mode ? CMD_LOAD : CMD_SEED;
    incoming.restart = items.seed_start;
    incoming.last    = items.set_last;
    incoming.data    = items.item_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/fys_rng.sv -----
// Generator: seed hash, xorshift128 words and the shared multiply-add used
// to rebuild the words after each seed byte. Depends on fys_pkg.
module fys_rng (
  input  logic              clk,
  input  logic              rst,
  input  fys_pkg::rng_ctl_t ctl,
  output fys_pkg::rng_sts_t sts
);
  import fys_pkg::*;

  logic [31:0] w0, w1, w2, w3;
  logic [31:0] hash;
  logic [1:0]  phase;
  logic        busy;
  logic [31:0] hash_base;
  logic [31:0] hash_next;
  logic [31:0] mul_src;
  logic [31:0] mul_out;
  logic [31:0] t;
  logic [31:0] word_next;

  assign hash_base = ctl.restart ? '0 : hash;
  assign hash_next = (hash_base << HASH_SHIFT) - hash_base + {24'b0, ctl.seed_byte};

  always_comb begin
    case (phase)
      2'd1:    mul_src = w0;
      2'd2:    mul_src = w1;
      default: mul_src = w2;
    endcase
  end
  assign mul_out = mul_src * LCG_MUL + LCG_ADD;

  assign t         = w0 ^ (w0 << XS_SHL);
  assign word_next = (w3 ^ (w3 >> XS_SHR_W3)) ^ (t ^ (t >> XS_SHR_T));

  assign sts.busy = busy;
  assign sts.word = word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      w0    <= '0;
      w1    <= '0;
      w2    <= '0;
      w3    <= '0;
      hash  <= '0;
      phase <= '0;
      busy  <= 1'b0;
    end else if (busy) begin
      // Chain one multiply-add per cycle into the next word.
      case (phase)
        2'd1: begin
          w1    <= mul_out;
          phase <= 2'd2;
        end
        2'd2: begin
          w2    <= mul_out;
          phase <= 2'd3;
        end
        default: begin
          w3    <= mul_out;
          phase <= 2'd0;
          busy  <= 1'b0;
        end
      endcase
    end else if (ctl.seed) begin
      hash  <= hash_next;
      w0    <= hash_next;
      phase <= 2'd1;
      busy  <= 1'b1;
    end else if (ctl.step) begin
      w0 <= w1;
      w1 <= w2;
      w2 <= w3;
      w3 <= word_next;
    end
  end

endmodule

// ----- rtl/fys_back.sv -----
// Back end: element buffer, shuffle sequencer and result register.
// Depends on fys_pkg and fys_out_if; drives the generator controls of fys_rng.
module fys_back (
  input  logic              clk,
  input  logic              rst,
  input  fys_pkg::cmd_t     cmd,
  input  logic              cmd_valid,
  output logic              pop,
  output fys_pkg::rng_ctl_t rng_ctl,
  input  fys_pkg::rng_sts_t rng_sts,
  fys_out_if.source         results
);
  import fys_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SEED     = 8'b0000_0010,
    S_DRAW     = 8'b0000_0100,
    S_READ     = 8'b0000_1000,
    S_WR_I     = 8'b0001_0000,
    S_WR_J     = 8'b0010_0000,
    S_EMIT_RD  = 8'b0100_0000,
    S_EMIT_PUT = 8'b1000_0000
  } state_t;

  state_t                   state, state_next;
  logic [ELEMENT_WIDTH-1:0] mem [MAX_ELEMENTS];
  logic [ELEMENT_WIDTH-1:0] rd_a, rd_b;
  logic                     rd_en;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data;

  logic [CNT_W-1:0]         count, count_next;
  logic                     overflow, overflow_next;
  logic [CNT_W-1:0]         set_size, set_size_next;
  logic [IDX_W-1:0]         idx_i, idx_i_next;
  logic [IDX_W-1:0]         idx_j, idx_j_next;

  logic                     out_valid;
  logic [VALUE_W-1:0]       out_value;
  logic                     out_last;
  logic                     out_overflow;
  logic                     out_load;
  logic                     slot_free;
  logic                     emit_last;

  logic                     has_room;
  logic [CNT_W-1:0]         limit;
  logic [CNT_W-1:0]         draw;
  logic                     draw_ok;

  assign has_room  = (count < CNT_W'(MAX_ELEMENTS));
  assign limit     = CNT_W'(idx_i) + 1'b1;
  assign draw      = rng_sts.word[CNT_W-1:0] & bit_length_mask(limit);
  assign draw_ok   = (draw < limit);
  assign slot_free = !out_valid || results.ready;
  assign emit_last = ((CNT_W'(idx_i) + 1'b1) == set_size);

  always_comb begin
    state_next       = state;
    count_next       = count;
    overflow_next    = overflow;
    set_size_next    = set_size;
    idx_i_next       = idx_i;
    idx_j_next       = idx_j;
    pop              = 1'b0;
    rng_ctl.seed      = 1'b0;
    rng_ctl.restart   = cmd.restart;
    rng_ctl.seed_byte = cmd.data[7:0];
    rng_ctl.step      = 1'b0;
    rd_en            = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = idx_i;
    wr_data          = ELEMENT_WIDTH'(cmd.data);
    out_load         = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          case (cmd.kind)
            CMD_SEED: begin
              rng_ctl.seed = 1'b1;
              state_next   = S_SEED;
            end
            CMD_LOAD: begin
              // Store while there is room, else drop and flag the set.
              if (has_room) begin
                wr_en      = 1'b1;
                wr_addr    = count[IDX_W-1:0];
                count_next = count + 1'b1;
              end else begin
                overflow_next = 1'b1;
              end
              if (cmd.last) begin
                set_size_next = count_next;
                if (count_next == CNT_W'(1)) begin
                  idx_i_next = '0;
                  state_next = S_EMIT_RD;
                end else begin
                  idx_i_next = IDX_W'(count_next - 1'b1);
                  state_next = S_DRAW;
                end
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_SEED: begin
        if (!rng_sts.busy) begin
          state_next = S_IDLE;
        end
      end

      S_DRAW: begin
        // Redraw until the masked word falls below the limit.
        rng_ctl.step = 1'b1;
        if (draw_ok) begin
          idx_j_next = draw[IDX_W-1:0];
          if (draw[IDX_W-1:0] != idx_i) begin
            state_next = S_READ;
          end else if (idx_i == IDX_W'(1)) begin
            idx_i_next = '0;
            state_next = S_EMIT_RD;
          end else begin
            idx_i_next = idx_i - 1'b1;
          end
        end
      end

      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_WR_I;
      end

      S_WR_I: begin
        wr_en      = 1'b1;
        wr_addr    = idx_i;
        wr_data    = rd_b;
        state_next = S_WR_J;
      end

      S_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = rd_a;
        if (idx_i == IDX_W'(1)) begin
          idx_i_next = '0;
          state_next = S_EMIT_RD;
        end else begin
          idx_i_next = idx_i - 1'b1;
          state_next = S_DRAW;
        end
      end

      S_EMIT_RD: begin
        rd_en      = 1'b1;
        state_next = S_EMIT_PUT;
      end

      S_EMIT_PUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (emit_last) begin
            count_next    = '0;
            overflow_next = 1'b0;
            state_next    = S_IDLE;
          end else begin
            idx_i_next = idx_i + 1'b1;
            state_next = S_EMIT_RD;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Element buffer: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[idx_i];
      rd_b <= mem[idx_j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      overflow  <= 1'b0;
      set_size  <= '0;
      idx_i     <= '0;
      idx_j     <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
      set_size <= set_size_next;
      idx_i    <= idx_i_next;
      idx_j    <= idx_j_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value    <= VALUE_W'(rd_a);
      out_last     <= emit_last;
      out_overflow <= overflow;
    end
  end

  assign results.valid        = out_valid;
  assign results.out_value    = out_value;
  assign results.out_last     = out_last;
  assign results.out_overflow = out_overflow;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count exceeds capacity");

  a_swap_below: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (idx_j < idx_i))
    else $error("swap partner not below current index");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || results.ready))
    else $error("result register overwritten while held");

  a_step_idle_rng: assert property (@(posedge clk) disable iff (rst)
    rng_ctl.step |-> !rng_sts.busy)
    else $error("generator stepped while reseeding");
`endif

endmodule

// ----- rtl/xorshift_fisher_yates_shuffler.sv -----
// Top level of the xorshift Fisher-Yates shuffler.
// Depends on fys_pkg, fys_in_if, fys_out_if, fys_front, fys_rng and fys_back.
//
// Usage:
//   items   - input channel (valid/ready). mode 0 carries a seed byte in the
//             low 8 bits of item_value (seed_start restarts the hash); mode 1
//             carries an element, and set_last marks the last one of a set.
//   results - result channel (valid/ready). One transaction per stored
//             element, in shuffled order; out_last flags the final one and
//             out_overflow is set on all of a set's results if elements past
//             capacity were dropped.
// Flow:
//   A two-entry queue holds accepted transactions, so the input keeps
//   flowing while the back end works. The back end takes one queued command
//   at a time: an element load is stored directly, while a seed byte keeps
//   the back end in S_SEED while one shared 32x32 multiply-add rebuilds each
//   generator word after the first. Each Fisher-Yates step makes one
//   generator draw per attempt (under two draws on average), then the read
//   and two single-port writes of a swap, which is skipped when the draw
//   equals the index. Each result passes through the registered buffer read
//   (S_EMIT_RD, then S_EMIT_PUT) before it enters the result register.
// Reset: generator words, hash, element count and overflow flag clear; the
//   element buffer needs no clearing. When the receiver stalls, the result
//   register holds and the sequencer waits; the queue fills and then
//   deasserts items.ready.
module xorshift_fisher_yates_shuffler (
  input  logic      clk,
  input  logic      rst,
  fys_in_if.sink    items,
  fys_out_if.source results
);
  import fys_pkg::*;

  cmd_t     cmd;
  logic     cmd_valid;
  logic     pop;
  rng_ctl_t rng_ctl;
  rng_sts_t rng_sts;

  // Accept and classify input transactions into the command queue.
  fys_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .pop       (pop),
    .cmd       (cmd),
    .cmd_valid (cmd_valid)
  );

  // Hold the seed hash and xorshift128 state; advance on each draw.
  fys_rng u_rng (
    .clk (clk),
    .rst (rst),
    .ctl (rng_ctl),
    .sts (rng_sts)
  );

  // Load, shuffle and emit each set.
  fys_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .pop       (pop),
    .rng_ctl   (rng_ctl),
    .rng_sts   (rng_sts),
    .results   (results)
  );

endmodule

// ----- tb/tb_xorshift_fisher_yates_shuffler.sv -----
// Self-checking testbench for the xorshift Fisher-Yates shuffler.
// Depends on fys_in_if, fys_out_if and xorshift_fisher_yates_shuffler; it keeps
// its own model of the hash, generator and element buffer to predict results.
module tb_xorshift_fisher_yates_shuffler;

  // Port encoding of the mode field.
  localparam logic MODE_SEED = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Shuffler arithmetic, kept apart from the RTL on purpose.
  localparam int          CAPACITY   = 64;
  localparam logic [31:0] HASH_MULT  = 32'd31;
  localparam logic [31:0] LCG_MULT   = 32'd1103515245;
  localparam logic [31:0] LCG_INC    = 32'd12345;

  localparam int RANDOM_ITEMS = 24;
  localparam int HOLD_SET     = 4;     // small set shuffled while the receiver holds off
  localparam int LONG_HOLD    = 1500;  // receiver hold-off, in cycles
  localparam int SETTLE       = 40;    // covers a queued seed byte after the last result
  localparam int DIR_ROWS     = 23;

  // One input transaction, plus an optional typed-in result for rows whose
  // outcome is obvious (single-element sets produce exactly that element).
  typedef struct packed {
    logic        mode;
    logic [15:0] value;
    logic        start;
    logic        last;
    logic        typed;
    logic [15:0] want_value;
    logic        want_last;
    logic        want_ovf;
  } in_row_t;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        ovf;
  } shuffled_t;

  logic clk;
  logic rst;

  fys_in_if  items_ch ();
  fys_out_if results_ch ();

  xorshift_fisher_yates_shuffler i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Model state: generator words, seed hash and the set being collected.
  logic [31:0] rng_state [4];
  logic [31:0] seed_hash;
  logic [15:0] set_store [CAPACITY];
  int          set_fill;
  logic        set_dropped;

  shuffled_t   pending_results [$];
  int          mismatch_count;
  int          result_index;
  bit          send_burst;
  bit          hold_request;

  // Directed rows: reset state, field extremes, ignored fields, the all-zero
  // generator, reseeding in the middle of the run and small multi-element sets.
  in_row_t directed_rows [DIR_ROWS] = '{
    // single element straight after reset; seed_start is ignored on loads
    '{MODE_LOAD, 16'h0000, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
    '{MODE_LOAD, 16'hFFFF, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0},
    // two elements under the all-zero generator: every draw returns zero
    '{MODE_LOAD, 16'h1234, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h5678, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    // seed byte with high bits set and set_last high: both ignored
    '{MODE_SEED, 16'hFF00, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h8001, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h7FFE, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h00FF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    // chained seed bytes without restart
    '{MODE_SEED, 16'h00FF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_SEED, 16'h00A5, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    // single element under a live generator: no draws, emitted alone
    '{MODE_LOAD, 16'hFFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0},
    '{MODE_SEED, 16'h005A, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h0001, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h0002, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h0004, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h0008, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h0010, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h0020, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h0040, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h0080, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    // restart with an all-ones value, then a two-element set
    '{MODE_SEED, 16'hFFFF, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'hAAAA, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{MODE_LOAD, 16'h5555, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}
  };

  // Advance the xorshift128 generator and return the new top word.
  function automatic logic [31:0] next_rand();
    logic [31:0] t;
    logic [31:0] w3;
    t  = rng_state[0] ^ (rng_state[0] << 11);
    w3 = rng_state[3];
    rng_state[0] = rng_state[1];
    rng_state[1] = rng_state[2];
    rng_state[2] = w3;
    rng_state[3] = (w3 ^ (w3 >> 19)) ^ (t ^ (t >> 8));
    return rng_state[3];
  endfunction

  // Rejection sampling: mask to the bit length of limit, redraw until below.
  function automatic int draw_below(input int limit);
    logic [31:0] mask;
    logic [31:0] m;
    logic [31:0] v;
    int          nbits;
    nbits = 0;
    m = limit;
    while (m != 0) begin
      nbits++;
      m = m >> 1;
    end
    mask = (32'd1 << nbits) - 32'd1;
    do begin
      v = next_rand() & mask;
    end while (v >= limit);
    return int'(v);
  endfunction

  // Fold one accepted transaction into the model and queue what it produces.
  function automatic void shuffle_accept(input in_row_t it);
    int          i;
    int          j;
    logic [15:0] tmp;
    shuffled_t   res;
    if (it.mode == MODE_SEED) begin
      if (it.start) seed_hash = 32'd0;
      seed_hash    = seed_hash * HASH_MULT + {24'd0, it.value[7:0]};
      rng_state[0] = seed_hash;
      rng_state[1] = rng_state[0] * LCG_MULT + LCG_INC;
      rng_state[2] = rng_state[1] * LCG_MULT + LCG_INC;
      rng_state[3] = rng_state[2] * LCG_MULT + LCG_INC;
      return;
    end
    // drop anything past capacity but remember it for the whole set
    if (set_fill < CAPACITY) begin
      set_store[set_fill] = it.value;
      set_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.last) return;
    for (i = set_fill - 1; i >= 1; i--) begin
      j = draw_below(i + 1);
      tmp          = set_store[i];
      set_store[i] = set_store[j];
      set_store[j] = tmp;
    end
    if (it.typed) begin
      res = '{it.want_value, it.want_last, it.want_ovf};
      pending_results.push_back(res);
    end else begin
      for (i = 0; i < set_fill; i++) begin
        res = '{set_store[i], (i == set_fill - 1), set_dropped};
        pending_results.push_back(res);
      end
    end
    set_fill    = 0;
    set_dropped = 1'b0;
  endfunction

  function automatic in_row_t make_row(input logic mode, input logic [15:0] value,
                                       input logic start, input logic last);
    in_row_t r;
    r = '{mode, value, start, last, 1'b0, 16'h0000, 1'b0, 1'b0};
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction: drive at the falling edge, hold until accepted at a
  // rising edge, then return at the next falling edge with valid still high so
  // back-to-back transactions need no second assignment to valid.
  task automatic offer(input in_row_t it);
    int gap;
    gap = send_burst ? 0 : idle_len();
    if (gap > 0) begin
      items_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_ch.valid      = 1'b1;
    items_ch.mode       = it.mode;
    items_ch.item_value = it.value;
    items_ch.seed_start = it.start;
    items_ch.set_last   = it.last;
    do @(posedge clk); while (!items_ch.ready);
    shuffle_accept(it);
    @(negedge clk);
  endtask

  // Pause the sender until every predicted result is back, then let a queued
  // seed byte (which produces nothing) finish.
  task automatic quiesce();
    items_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Receiver: random stalls with streaks of steady ready, plus one long
  // hold-off on request so the block backs up into its input queue.
  initial begin : receiver
    int stall_left;
    int streak_left;
    stall_left  = 0;
    streak_left = 0;
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request     = 1'b0;
        results_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (stall_left > 0) begin
        results_ch.ready = 1'b0;
        stall_left--;
      end else begin
        results_ch.ready = 1'b1;
        if (streak_left > 0) begin
          streak_left--;
        end else if ($urandom_range(0, 15) == 0) begin
          streak_left = $urandom_range(20, 60);
        end else if ($urandom_range(0, 2) == 0) begin
          stall_left = idle_len();
        end
      end
    end
  end

  // Compare each accepted result with the oldest prediction, field by field.
  always @(posedge clk) begin : check_results
    shuffled_t got;
    shuffled_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      got = '{results_ch.out_value, results_ch.out_last, results_ch.out_overflow};
      if (pending_results.size() == 0) begin
        $display("%0t: result %0d unexpected, expected none, got value %h last %b ovf %b",
                 $time, result_index, got.value, got.last, got.ovf);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: result %0d out_value expected %h got %h",
                   $time, result_index, want.value, got.value);
          mismatch_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: result %0d out_last expected %b got %b",
                   $time, result_index, want.last, got.last);
          mismatch_count++;
        end
        if (got.ovf !== want.ovf) begin
          $display("%0t: result %0d out_overflow expected %b got %b",
                   $time, result_index, want.ovf, got.ovf);
          mismatch_count++;
        end
      end
      result_index++;
    end
  end

  initial begin : watchdog
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int n_sent;
    int kind;
    int size;
    int k;
    n_sent         = 0;
    mismatch_count = 0;
    result_index   = 0;
    send_burst     = 1'b0;
    hold_request   = 1'b0;
    seed_hash      = 32'd0;
    set_fill       = 0;
    set_dropped    = 1'b0;
    for (k = 0; k < 4; k++) rng_state[k] = 32'd0;
    items_ch.valid      = 1'b0;
    items_ch.mode       = MODE_SEED;
    items_ch.item_value = 16'h0000;
    items_ch.seed_start = 1'b0;
    items_ch.set_last   = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r]) offer(directed_rows[r]);
    quiesce();

    // Full buffer: hold the receiver off while a small set is shuffled and
    // waits to be emitted, then keep offering a 66-element set so the queue
    // fills and input stalls. That set drops two elements, its marked-last
    // one among them.
    hold_request = 1'b1;
    for (k = 0; k < HOLD_SET; k++) begin
      offer(make_row(MODE_LOAD, $urandom_range(0, 65535), $urandom_range(0, 1),
                     k == HOLD_SET - 1));
    end
    for (k = 0; k < CAPACITY + 2; k++) begin
      offer(make_row(MODE_LOAD, $urandom_range(0, 65535), $urandom_range(0, 1),
                     k == CAPACITY + 1));
    end
    quiesce();

    // Random part: mostly well-formed seed runs and sets with random content,
    // some sets broken up by a reseed, and stray transactions as noise.
    while (n_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      send_burst = ($urandom_range(0, 3) == 0);
      if (kind < 2) begin
        size = $urandom_range(1, 4);
        for (k = 0; k < size; k++) begin
          offer(make_row(MODE_SEED, $urandom_range(0, 65535), $urandom_range(0, 1),
                         $urandom_range(0, 1)));
          n_sent++;
        end
      end else if (kind < 9) begin
        size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (k = 0; k < size; k++) begin
          // reseed in the middle of a set now and then
          if ($urandom_range(0, 11) == 0) begin
            offer(make_row(MODE_SEED, $urandom_range(0, 65535), $urandom_range(0, 1),
                           $urandom_range(0, 1)));
            n_sent++;
          end
          offer(make_row(MODE_LOAD, $urandom_range(0, 65535), $urandom_range(0, 1),
                         k == size - 1));
          n_sent++;
        end
      end else begin
        offer(make_row($urandom_range(0, 1), $urandom_range(0, 65535),
                       $urandom_range(0, 1), $urandom_range(0, 1)));
        n_sent++;
      end
      send_burst = 1'b0;
    end
    items_ch.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fys_pkg.sv
rtl/fys_in_if.sv
rtl/fys_out_if.sv
rtl/fys_front.sv
rtl/fys_rng.sv
rtl/fys_back.sv
rtl/xorshift_fisher_yates_shuffler.sv
tb/tb_xorshift_fisher_yates_shuffler.sv
